### src/usv_pkg.sv
package usv_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 11;
    localparam int CP_W            = 21;
    localparam int LEN_W           = 3;
    localparam int BITS_W          = 7;
    localparam int SCALAR_CAP_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
    localparam logic [5:0]        CONT_MASK = 6'h3F;

    localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4     = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    localparam int CLS_W = 3;
    localparam logic [CLS_W-1:0] CLS_ASCII = 3'd0;
    localparam logic [CLS_W-1:0] CLS_LEAD2 = 3'd1;
    localparam logic [CLS_W-1:0] CLS_LEAD3 = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LEAD4 = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CONT  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BAD   = 3'd5;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [BITS_W-1:0] bits;
        logic              last;
    } item_t;

endpackage

### src/usv_if.sv
interface usv_byte_if;
    import usv_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface usv_result_if;
    import usv_pkg::*;

    logic             valid;
    logic             ready;
    logic             scalar_ready;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] scalar_bytes;
    logic             error_flag;
    logic             text_end;
    logic             text_valid;

    modport source (output valid, output scalar_ready, output code_point,
                    output scalar_bytes, output error_flag, output text_end,
                    output text_valid, input ready);
    modport sink (input valid, input scalar_ready, input code_point,
                  input scalar_bytes, input error_flag, input text_end,
                  input text_valid, output ready);
endinterface

interface usv_cfg_if;
    import usv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] scalar_cap;

    modport source (output valid, output scalar_cap, input ready);
    modport sink (input valid, input scalar_cap, output ready);
endinterface

### src/usv_front.sv
module usv_front (
    input  logic           clk,
    input  logic           rst_n,
    usv_byte_if.sink       rx,
    output logic           push_valid,
    output usv_pkg::item_t push_item,
    input  logic           queue_full
);
    import usv_pkg::*;

    logic  hold_valid_reg;
    item_t hold_item_reg;
    item_t class_item;

    always_comb
    begin
        class_item.last = rx.last_byte;
        class_item.bits = '0;
        if (rx.byte_in[7] == 1'b0)
        begin
            class_item.cls  = CLS_ASCII;
            class_item.bits = rx.byte_in[BITS_W-1:0];
        end
        else if (rx.byte_in[7:6] == 2'b10)
        begin
            class_item.cls  = CLS_CONT;
            class_item.bits = {1'b0, rx.byte_in[5:0]};
        end
        else if (rx.byte_in >= LEAD2_LO && rx.byte_in <= LEAD2_HI)
        begin
            class_item.cls  = CLS_LEAD2;
            class_item.bits = {2'b00, rx.byte_in[4:0]};
        end
        else if (rx.byte_in >= LEAD3_LO && rx.byte_in <= LEAD3_HI)
        begin
            class_item.cls  = CLS_LEAD3;
            class_item.bits = {3'b000, rx.byte_in[3:0]};
        end
        else if (rx.byte_in >= LEAD4_LO && rx.byte_in <= LEAD4_HI)
        begin
            class_item.cls  = CLS_LEAD4;
            class_item.bits = {4'b0000, rx.byte_in[2:0]};
        end
        else
        begin
            class_item.cls = CLS_BAD;
        end
    end

    assign rx.ready   = !hold_valid_reg || !queue_full;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            hold_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            hold_item_reg <= class_item;
        end
    end

endmodule

### src/usv_queue.sv
module usv_queue #(
    parameter int DEPTH = usv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  usv_pkg::item_t push_item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output usv_pkg::item_t pop_item
);
    import usv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/usv_back.sv
module usv_back #(
    parameter int SCALAR_CAP = usv_pkg::SCALAR_CAP_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    usv_cfg_if.sink        cfg,
    input  logic           queue_empty,
    input  usv_pkg::item_t pop_item,
    output logic           pop,
    usv_result_if.source   tx
);
    import usv_pkg::*;

    localparam int CAP_BITS = $clog2(SCALAR_CAP + 1);
    localparam int LIM_W    = (CAP_BITS > CFG_W) ? CAP_BITS : CFG_W;
    localparam int CNT_W    = LIM_W + 1;

    logic [LIM_W-1:0] max_reg;
    logic             sticky_reg;
    logic [1:0]       left_reg;
    logic [LEN_W-1:0] len_reg;
    logic [CP_W-1:0]  part_reg;
    logic [CNT_W-1:0] count_reg;

    logic             sticky_next;
    logic [1:0]       left_next;
    logic [LEN_W-1:0] len_next;
    logic [CP_W-1:0]  part_next;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic             err;
    logic             good;
    logic             scalar_ok;

    logic             out_valid_reg;
    logic             res_scalar_reg;
    logic [CP_W-1:0]  res_cp_reg;
    logic [LEN_W-1:0] res_len_reg;
    logic             res_error_reg;
    logic             res_end_reg;
    logic             res_text_ok_reg;

    assign cfg.ready = 1'b1;
    assign pop       = !queue_empty && (!out_valid_reg || tx.ready);
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        sticky_next = sticky_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        part_next   = part_reg;
        count_next  = count_reg;
        err         = 1'b0;
        good        = 1'b0;
        scalar_ok   = 1'b0;
        if (!sticky_reg)
        begin
            if (left_reg == 2'd0)
            begin
                unique case (pop_item.cls)
                    CLS_ASCII:
                    begin
                        len_next  = 3'd1;
                        left_next = 2'd0;
                    end
                    CLS_LEAD2:
                    begin
                        len_next  = 3'd2;
                        left_next = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        len_next  = 3'd3;
                        left_next = 2'd2;
                    end
                    CLS_LEAD4:
                    begin
                        len_next  = 3'd4;
                        left_next = 2'd3;
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
                part_next = CP_W'(pop_item.bits);
            end
            else if (pop_item.cls != CLS_CONT)
            begin
                err = 1'b1;
            end
            else
            begin
                part_next = {part_reg[CP_W-7:0], pop_item.bits[5:0] & CONT_MASK};
                left_next = left_reg - 2'd1;
            end

            if (!err && left_next == 2'd0)
            begin
                scalar_ok = (part_next != '0)
                    && !(len_next == 3'd3 && part_next < CP_MIN3)
                    && !(len_next == 3'd4 && part_next < CP_MIN4)
                    && !(part_next >= CP_SURR_LO && part_next <= CP_SURR_HI)
                    && (part_next <= CP_MAX);
                if (!scalar_ok)
                begin
                    err = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                    if (count_inc > CNT_W'(max_reg))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        good = 1'b1;
                    end
                end
            end

            if (!err && pop_item.last && left_next != 2'd0)
            begin
                err = 1'b1;
            end

            if (err)
            begin
                sticky_next = 1'b1;
                left_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= LIM_W'(SCALAR_CAP);
            sticky_reg <= 1'b0;
            left_reg   <= '0;
            len_reg    <= '0;
            part_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_reg <= LIM_W'(cfg.scalar_cap);
            end
            if (pop)
            begin
                if (pop_item.last)
                begin
                    sticky_reg <= 1'b0;
                    left_reg   <= '0;
                    count_reg  <= '0;
                end
                else
                begin
                    sticky_reg <= sticky_next;
                    left_reg   <= left_next;
                    count_reg  <= count_next;
                end
                len_reg  <= len_next;
                part_reg <= part_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_scalar_reg  <= good;
            res_cp_reg      <= good ? part_next : '0;
            res_len_reg     <= good ? len_next : '0;
            res_error_reg   <= sticky_next;
            res_end_reg     <= pop_item.last;
            res_text_ok_reg <= pop_item.last && !sticky_next;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.scalar_ready = res_scalar_reg;
    assign tx.code_point   = res_cp_reg;
    assign tx.scalar_bytes = res_len_reg;
    assign tx.error_flag   = res_error_reg;
    assign tx.text_end     = res_end_reg;
    assign tx.text_valid   = res_text_ok_reg;

endmodule

### src/utf8_scalar_validator_top.sv
// UTF-8 scalar validator.
// The rx channel takes one request per text byte, with last_byte set on the
// final byte of a text. The tx channel returns exactly one result per byte:
// the code point and encoded length when a valid scalar completes at that
// byte, the sticky error flag for the text, and on the final byte text_end
// and text_valid. The cfg channel writes the scalar cap of a text and is
// always ready; the user must write it only while no byte is in flight,
// as the block does not enforce this. A byte passes through a classifying
// register, a queue (two entries by default) and the decoding stage with its
// output register before its result is valid. One byte per cycle is sustained
// while the receiver does not stall; the rate is set by the decoding stage,
// whose state is updated once per byte. When the receiver stalls, the result
// is held and the queue and the front register keep taking bytes until they
// are full, then rx.ready drops. Reset clears all text state and loads the
// scalar cap with its default; the block is ready once reset is released.
module utf8_scalar_validator_top #(
    parameter int SCALAR_CAP  = usv_pkg::SCALAR_CAP_DEF,
    parameter int QUEUE_DEPTH = usv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    usv_byte_if.sink     rx,
    usv_result_if.source tx,
    usv_cfg_if.sink      cfg
);
    import usv_pkg::*;

    logic  push_valid;
    item_t push_item;
    logic  queue_full;
    logic  queue_empty;
    logic  pop;
    item_t pop_item;

    usv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    usv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .empty      (queue_empty),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    usv_back #(
        .SCALAR_CAP (SCALAR_CAP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .tx          (tx)
    );

endmodule

### src/usv_checker.sv
module usv_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      tx_valid,
    input logic                      tx_ready,
    input logic                      scalar_ready,
    input logic [usv_pkg::CP_W-1:0]  code_point,
    input logic [usv_pkg::LEN_W-1:0] scalar_bytes,
    input logic                      error_flag,
    input logic                      text_end,
    input logic                      text_valid
);
    import usv_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(code_point) && $stable(text_end))
        else $error("Result changed while stalled.");

    a_scalar_legal: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && scalar_ready |-> code_point != '0 && code_point <= CP_MAX
            && scalar_bytes != '0 && !error_flag)
        else $error("Reported scalar is not legal.");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !scalar_ready |-> code_point == '0 && scalar_bytes == '0)
        else $error("Payload not cleared without a scalar.");

    a_text_ok: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && text_valid |-> text_end && !error_flag)
        else $error("Text reported valid with an error or before its end.");

endmodule

bind utf8_scalar_validator_top usv_checker u_usv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tx_valid     (tx.valid),
    .tx_ready     (tx.ready),
    .scalar_ready (tx.scalar_ready),
    .code_point   (tx.code_point),
    .scalar_bytes (tx.scalar_bytes),
    .error_flag   (tx.error_flag),
    .text_end     (tx.text_end),
    .text_valid   (tx.text_valid)
);
